FILE: hw/rtl/xilr_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// xilr_pkg
// Types, opcode class table and codes shared by the x86 length decoder.
// -----------------------------------------------------------------------------
package xilr_pkg;

    typedef enum logic [3:0] {
        K_BAD = 4'd0, K_ONE = 4'd1, K_I8 = 4'd2, K_IV = 4'd3,
        K_RM  = 4'd4, K_RM8 = 4'd5, K_RMV = 4'd6, K_F3 = 4'd7,
        K_F4  = 4'd8, K_F5 = 4'd9, K_F7 = 4'd10, K_PFX = 4'd11,
        K_OSZ = 4'd12, K_ASZ = 4'd13, K_TWO = 4'd14, K_REL = 4'd15
    } t_op_class;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0, PH_MODRM = 3'd1, PH_SIB = 3'd2,
        PH_TAIL = 3'd3, PH_HALT = 3'd4
    } t_phase;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OPCODE = 3'd1;
    localparam logic [2:0] ERR_ASIZE  = 3'd2;
    localparam logic [2:0] ERR_TWOB   = 3'd3;
    localparam logic [2:0] ERR_LONG   = 3'd4;

    localparam logic [0:0] REG_DELTA = 1'b0;
    localparam logic [0:0] REG_MINLEN = 1'b1;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        insn_end;
        logic [3:0]  insn_length;
        logic [15:0] run_total;
        logic        run_done;
        logic [2:0]  error_kind;
    } t_result;

    localparam logic [3:0] OP_CLASS [256] = '{
        4,4,4,4,2,3,1,1,4,4,4,4,2,3,1,14,
        4,4,4,4,2,3,1,1,4,4,4,4,2,3,1,1,
        4,4,4,4,2,3,11,1,4,4,4,4,2,3,11,1,
        4,4,4,4,2,3,11,1,4,4,4,4,2,3,11,1,
        1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,
        1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,
        1,1,4,4,11,11,12,13,3,6,2,5,1,1,1,1,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        5,6,5,5,4,4,4,4,4,4,4,4,4,4,4,4,
        1,1,1,1,1,1,1,1,1,1,10,1,1,1,1,1,
        9,9,9,9,1,1,1,1,2,3,1,1,1,1,1,1,
        2,2,2,2,2,2,2,2,3,3,3,3,3,3,3,3,
        5,5,7,1,4,4,5,0,8,1,7,1,1,2,1,1,
        4,4,4,4,2,2,0,1,4,4,4,4,4,4,4,4,
        2,2,2,2,2,2,2,2,15,15,0,0,0,0,0,0,
        11,0,11,11,1,1,5,6,1,1,1,1,1,1,4,4
    };

    function automatic t_op_class op_class(input logic [7:0] b);
        return t_op_class'(OP_CLASS[b]);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/xilr_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// xilr_stream_if
// Valid/ready channel carrying one payload of parameterized type.
// -----------------------------------------------------------------------------
interface xilr_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/xilr_cfg_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// xilr_cfg_if
// Register write channel: index and data with valid/ready.
// -----------------------------------------------------------------------------
interface xilr_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/xilr_decoder.sv
`default_nettype none
// -----------------------------------------------------------------------------
// xilr_decoder
// Decode state and one-byte-per-cycle step of the length decoder, taken when i_step is high.
// -----------------------------------------------------------------------------
module xilr_decoder #(
    parameter int MAX_INSN_LEN = 15
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [7:0]           i_byte,
    input  wire logic [31:0]          i_delta,
    input  wire logic [15:0]          i_min_len,
    output xilr_pkg::t_result         o_result
);

    xilr_pkg::t_phase r_phase, n_phase;
    logic        r_osz, n_osz;
    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_modrm, n_modrm;
    logic [3:0]  r_left, n_left;
    logic        r_rel, n_rel;
    logic [1:0]  r_ridx, n_ridx;
    logic        r_carry, n_carry;
    logic [3:0]  r_ibytes, n_ibytes;
    logic [15:0] r_total, n_total;
    logic [2:0]  r_err, n_err;

    function automatic logic [3:0] imm_size(input logic [7:0] op, input logic osz);
        xilr_pkg::t_op_class k;
        k = xilr_pkg::op_class(op);
        if (k == xilr_pkg::K_RM8) return 4'd1;
        if (k == xilr_pkg::K_RMV) return osz ? 4'd2 : 4'd4;
        return 4'd0;
    endfunction

    function automatic logic [3:0] disp_size(input logic [1:0] md, input logic [2:0] base);
        if (md == 2'd1) return 4'd1;
        if (md == 2'd2) return 4'd4;
        return (base == 3'd5) ? 4'd4 : 4'd0;
    endfunction

    always_comb begin
        xilr_pkg::t_op_class k;
        logic [2:0]  err;
        logic        endf;
        logic [3:0]  n;
        logic [8:0]  s;
        logic [16:0] sum;
        n_phase = r_phase; n_osz = r_osz; n_opcode = r_opcode; n_modrm = r_modrm;
        n_left = r_left; n_rel = r_rel; n_ridx = r_ridx; n_carry = r_carry;
        n_ibytes = r_ibytes; n_total = r_total; n_err = r_err;
        err = xilr_pkg::ERR_NONE; endf = 1'b0; n = 4'd0; s = '0; sum = '0;
        k = xilr_pkg::op_class(i_byte);
        o_result.out_byte = i_byte;
        o_result.insn_length = 4'd0;
        o_result.run_total = r_total;
        o_result.run_done = 1'b0;
        if (r_phase == xilr_pkg::PH_HALT) begin
        end else if (32'(r_ibytes) >= 32'(MAX_INSN_LEN)) begin
            err = xilr_pkg::ERR_LONG;
        end else begin
            n_ibytes = r_ibytes + 4'd1;
            unique case (r_phase)
                xilr_pkg::PH_OPCODE: begin
                    priority case (k)
                        xilr_pkg::K_PFX: ;
                        xilr_pkg::K_OSZ: n_osz = 1'b1;
                        xilr_pkg::K_ASZ: err = xilr_pkg::ERR_ASIZE;
                        xilr_pkg::K_TWO: err = xilr_pkg::ERR_TWOB;
                        xilr_pkg::K_BAD: err = xilr_pkg::ERR_OPCODE;
                        xilr_pkg::K_ONE: endf = 1'b1;
                        xilr_pkg::K_RM, xilr_pkg::K_RM8, xilr_pkg::K_RMV: begin
                            n_opcode = i_byte;
                            n_phase = xilr_pkg::PH_MODRM;
                        end
                        default: begin
                            priority case (k)
                                xilr_pkg::K_I8: n = 4'd1;
                                xilr_pkg::K_IV: n = r_osz ? 4'd2 : 4'd4;
                                xilr_pkg::K_F3: n = 4'd2;
                                xilr_pkg::K_F4: n = 4'd3;
                                xilr_pkg::K_F7: n = 4'd6;
                                default: n = 4'd4;
                            endcase
                            if (k == xilr_pkg::K_REL && r_ibytes == 4'd0) begin
                                n_rel = 1'b1; n_ridx = 2'd0; n_carry = 1'b0;
                            end
                            n_left = n;
                            n_phase = xilr_pkg::PH_TAIL;
                        end
                    endcase
                end
                xilr_pkg::PH_MODRM, xilr_pkg::PH_SIB: begin
                    if (r_phase == xilr_pkg::PH_MODRM) begin
                        n_modrm = i_byte;
                        if (i_byte[7:6] == 2'd3) n = imm_size(r_opcode, r_osz);
                        else if (i_byte[2:0] == 3'd4) n = 4'd0;
                        else n = disp_size(i_byte[7:6], i_byte[2:0])
                                 + imm_size(r_opcode, r_osz);
                    end else begin
                        n = disp_size(r_modrm[7:6], i_byte[2:0]) + imm_size(r_opcode, r_osz);
                    end
                    if (r_phase == xilr_pkg::PH_MODRM && i_byte[7:6] != 2'd3
                        && i_byte[2:0] == 3'd4) begin
                        n_phase = xilr_pkg::PH_SIB;
                    end else if (n == 4'd0) begin
                        endf = 1'b1;
                    end else begin
                        n_left = n;
                        n_phase = xilr_pkg::PH_TAIL;
                    end
                end
                default: begin
                    if (r_rel) begin
                        s = {1'b0, i_byte} + {1'b0, i_delta[8*r_ridx +: 8]}
                            + {8'd0, r_carry};
                        o_result.out_byte = s[7:0];
                        n_carry = s[8];
                        n_ridx = r_ridx + 2'd1;
                    end
                    n_left = r_left - 4'd1;
                    if (n_left == 4'd0) endf = 1'b1;
                end
            endcase
        end
        if (err != xilr_pkg::ERR_NONE) begin
            n_err = err;
            n_phase = xilr_pkg::PH_HALT;
            endf = 1'b0;
        end
        if (endf) begin
            o_result.insn_length = n_ibytes;
            sum = {1'b0, r_total} + {13'd0, n_ibytes};
            n_total = sum[16] ? 16'hFFFF : sum[15:0];
            o_result.run_total = n_total;
            if (n_total >= i_min_len) begin
                o_result.run_done = 1'b1;
                n_total = 16'd0;
            end
            n_ibytes = 4'd0; n_osz = 1'b0; n_rel = 1'b0; n_ridx = 2'd0;
            n_carry = 1'b0; n_left = 4'd0; n_phase = xilr_pkg::PH_OPCODE;
        end
        o_result.insn_end = endf;
        o_result.error_kind = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xilr_pkg::PH_OPCODE; r_osz <= 1'b0; r_opcode <= '0;
            r_modrm <= '0; r_left <= '0; r_rel <= 1'b0; r_ridx <= '0;
            r_carry <= 1'b0; r_ibytes <= '0; r_total <= '0; r_err <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_osz <= n_osz; r_opcode <= n_opcode;
            r_modrm <= n_modrm; r_left <= n_left; r_rel <= n_rel; r_ridx <= n_ridx;
            r_carry <= n_carry; r_ibytes <= n_ibytes; r_total <= n_total;
            r_err <= n_err;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/x86_insn_length_relocator_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// x86_insn_length_relocator_core
// Streaming 32-bit x86 length decoder with rel32 relocation.
// -----------------------------------------------------------------------------
// One code byte is taken per beat and one result beat comes out for it, at a
// sustained rate of one byte per clock while neither side stalls. The input
// beat is held in a register; the decode step (opcode table lookup,
// ModRM/SIB sizing, an 8-bit add for relocation and a 16-bit run total
// compare) sits between that register and the result register. Decode
// state advances only when the held byte moves into the result register,
// so both sides can stall freely. Configuration writes are taken at any
// time and should be made while the block is idle.
module x86_insn_length_relocator_core #(
    parameter int MAX_INSN_LEN = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    xilr_stream_if.sink   in_ch,
    xilr_stream_if.source out_ch,
    xilr_cfg_if.sink      cfg_ch
);

    // Configuration registers.
    logic [31:0] r_delta;
    logic [15:0] r_min_len;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= 32'd0;
            r_min_len <= 16'd5;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                xilr_pkg::REG_DELTA:  r_delta <= cfg_ch.wdata;
                xilr_pkg::REG_MINLEN: r_min_len <= cfg_ch.wdata[15:0];
                default: ;
            endcase
        end
    end

    // Input register and result register; both advance on a decode step, and the input register also fills while empty.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    xilr_pkg::t_result r_out, n_out;
    logic       step;

    // The decode step fires when the held byte can move into the result slot.
    assign step = r_in_valid && (!r_out_valid || out_ch.ready);
    assign in_ch.ready = !r_in_valid || step;

    xilr_decoder #(.MAX_INSN_LEN(MAX_INSN_LEN)) u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_delta  (r_delta),
        .i_min_len(r_min_len),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ch.ready) r_in_valid <= in_ch.valid;
            if (step) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) r_in_byte <= in_ch.data;
        if (step) r_out <= n_out;
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

endmodule
`default_nettype wire
